// ===== hdl/bf4h_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf4h_pkg
// Shared types and constants of the four-hash Bloom filter core.
// ----------------------------------------------------------------------------
package bf4h_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned HASH_W      = 32;
  localparam int unsigned BIT_COUNT_W = 21;

  localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RST = 21'd1048576;
  localparam logic [HASH_W-1:0]      SEED_INIT     = 32'hAAAA_AAAA;

  localparam int unsigned SHIFT_ADD = 3;
  localparam int unsigned SHIFT_XOR = 5;
  localparam int unsigned SHIFT_MUL = 5;
  localparam int unsigned SHIFT_SEED = 17;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    HASH_SHIFT_ADD = 2'd0,
    HASH_SHIFT_XOR = 2'd1,
    HASH_MUL_MIX   = 2'd2,
    HASH_SEEDED    = 2'd3
  } hash_sel_e;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_CHK  = 6'b100000
  } state_e;

endpackage

// ===== hdl/bf4h_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf4h_if
// Valid/ready channels of the Bloom filter core: byte words in, answers out.
// ----------------------------------------------------------------------------
interface bf4h_in_if;
  import bf4h_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output cmd, output char_code, output last_char,
                  input ready);
  modport sink   (input valid, input cmd, input char_code, input last_char,
                  output ready);
endinterface

interface bf4h_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink   (input valid, input found, output ready);
endinterface

// ===== hdl/bloom_filter_four_hash_core.sv =====
// A byte that is not last only updates the four hashes; a last byte also runs, per hash,
//   a load, 32 restoring-division steps, a read and a check, in that order.
// Throughput: one byte per cycle inside a word; the shared divider sets word end.
// A query answer sits in an output register; the next word may start meanwhile.
// Reset: hashes and bit_count return to their initial values, then a clearing
//   pass writes zero to all (MAX_BITS+31)/32 words of the bit store, one word a cycle.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_four_hash_core
// Four-hash Bloom filter over byte-serial words with a shared serial divider.
// ----------------------------------------------------------------------------
module bloom_filter_four_hash_core #(
  parameter int unsigned MAX_BITS = 1048576
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bf4h_pkg::BIT_COUNT_W-1:0] cfg_data_i,
  bf4h_in_if.sink                          in_i,
  bf4h_out_if.source                       out_o
);
  import bf4h_pkg::*;

  localparam int unsigned STORE_WORDS = (MAX_BITS + 31) / 32;
  localparam int unsigned AW          = $clog2(STORE_WORDS);
  localparam int unsigned MW          = $clog2(MAX_BITS + 1);

  state_e                 state_q, state_d;
  logic [BIT_COUNT_W-1:0] bit_count_q;
  logic [HASH_W-1:0]      sa_q, sx_q, mm_q, sm_q;
  logic [HASH_W-1:0]      sa_n, sx_n, mm_n, sm_n;
  logic [HASH_W-1:0]      c_ext, prod;
  logic [HASH_W-1:0]      div_q, hsel;
  logic [MW-1:0]          mod_q, mod_n, r_q, r_n;
  logic [MW:0]            r_sh;
  logic [4:0]             cnt_q;
  logic [1:0]             k_q;
  logic                   cmd_q;
  logic                   found_acc_q;
  logic [AW-1:0]          clr_q;
  logic                   out_valid_q, found_q;
  logic                   in_fire, last_k, stall, bit_hit, answer_set;

  logic [31:0]            bit_store_q [STORE_WORDS];
  logic [31:0]            rd_q;
  logic [AW-1:0]          mem_addr;
  logic                   mem_we;
  logic [31:0]            mem_wdata;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.found = found_q;

  // hash update for the incoming byte
  assign c_ext = {{(HASH_W-CHAR_W){in_i.char_code[CHAR_W-1]}}, in_i.char_code};
  assign prod  = c_ext * (mm_q + c_ext);
  assign sa_n  = (sa_q + c_ext) << SHIFT_ADD;
  assign sx_n  = (sx_q << SHIFT_XOR) ^ c_ext;
  assign mm_n  = mm_q ^ ((mm_q << SHIFT_MUL) ^ prod);
  assign sm_n  = sm_q ^ ((sm_q << SHIFT_SEED) ^ (c_ext + (sm_q & c_ext)));

  always_comb begin
    if ((bit_count_q == '0) || (32'(bit_count_q) > 32'(MAX_BITS))) begin
      mod_n = MW'(MAX_BITS);
    end else begin
      mod_n = MW'(bit_count_q);
    end
  end

  always_comb begin
    unique case (hash_sel_e'(k_q))
      HASH_SHIFT_ADD: hsel = sa_q;
      HASH_SHIFT_XOR: hsel = sx_q;
      HASH_MUL_MIX:   hsel = mm_q;
      HASH_SEEDED:    hsel = sm_q;
      default:        hsel = sa_q;
    endcase
  end

  // one restoring-division step
  always_comb begin
    r_sh = {r_q, div_q[HASH_W-1]};
    if (r_sh >= {1'b0, mod_q}) begin
      r_n = MW'(r_sh - {1'b0, mod_q});
    end else begin
      r_n = MW'(r_sh);
    end
  end

  assign bit_hit    = rd_q[r_q[4:0]];
  assign last_k     = (k_q == 2'(HASH_SEEDED));
  assign stall      = last_k && (cmd_q == CMD_QUERY) && out_valid_q && !out_o.ready;
  assign answer_set = (state_q == ST_CHK) && !stall && last_k && (cmd_q == CMD_QUERY);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (clr_q == AW'(STORE_WORDS - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_fire && in_i.last_char) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'd31) state_d = ST_RD;
      ST_RD:   state_d = ST_CHK;
      ST_CHK: begin
        if (!stall) state_d = last_k ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_q | (32'd1 << r_q[4:0]);
    mem_addr  = AW'(r_q >> 5);
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
      mem_addr  = clr_q;
    end else if ((state_q == ST_CHK) && (cmd_q == CMD_INSERT)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bit_store_q[mem_addr] <= mem_wdata;
    end
    rd_q <= bit_store_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      bit_count_q <= BIT_COUNT_RST;
      sa_q        <= '0;
      sx_q        <= '0;
      mm_q        <= '0;
      sm_q        <= SEED_INIT;
      div_q       <= '0;
      mod_q       <= MW'(MAX_BITS);
      r_q         <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      cmd_q       <= CMD_INSERT;
      found_acc_q <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bit_count_q <= cfg_data_i;
      end
      if (answer_set) begin
        out_valid_q <= 1'b1;
        found_q     <= found_acc_q & bit_hit;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: clr_q <= clr_q + AW'(1);
        ST_IDLE: begin
          if (in_fire) begin
            sa_q <= sa_n;
            sx_q <= sx_n;
            mm_q <= mm_n;
            sm_q <= sm_n;
            if (in_i.last_char) begin
              cmd_q       <= in_i.cmd;
              mod_q       <= mod_n;
              k_q         <= '0;
              found_acc_q <= 1'b1;
            end
          end
        end
        ST_LOAD: begin
          div_q <= hsel;
          r_q   <= '0;
          cnt_q <= '0;
        end
        ST_DIV: begin
          r_q   <= r_n;
          div_q <= div_q << 1;
          cnt_q <= cnt_q + 5'd1;
        end
        ST_RD: ;
        ST_CHK: begin
          if (!stall) begin
            found_acc_q <= found_acc_q & bit_hit;
            k_q         <= k_q + 2'd1;
            if (last_k) begin
              sa_q <= '0;
              sx_q <= '0;
              mm_q <= '0;
              sm_q <= SEED_INIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (r_q < mod_q))
    else $error("remainder not below modulus");

  a_mod_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (mod_q != '0))
    else $error("zero modulus at division start");

  a_answer_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_CHK) && ($past(cmd_q) == CMD_QUERY))
    else $error("answer raised outside a query check");

  a_hold_on_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CHK) && stall) |=> (state_q == ST_CHK) && $stable(k_q))
    else $error("query finished while output still full");

endmodule
